// File: sv/hmc2d_pkg.sv
// Shared constants, register indexes and tables of the 2D Morton/Hilbert converter.
package hmc2d_pkg;

    // Field widths
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned ORDER_W = 5;
    localparam int unsigned LVL_W   = 5;
    localparam int unsigned DIGIT_W = 2;
    localparam int unsigned REMAP_W = 8;

    // Level counts
    localparam logic [ORDER_W-1:0] MAX_ORDER   = ORDER_W'(16);
    // Auto mode always runs the widest even count; leading zero level pairs
    // leave both the remap and the result unchanged.
    localparam logic [LVL_W-1:0]   AUTO_LEVELS = LVL_W'(18);

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ORDER = 1'b1;

    // Direction codes
    localparam logic DIR_M2H = 1'b0;
    localparam logic DIR_H2M = 1'b1;

    // Remap start value and XOR update tables, one byte per Hilbert digit
    localparam logic [REMAP_W-1:0] REMAP_INIT = 8'hb4;
    localparam logic [31:0]        M2H_TABLE  = 32'h8200_0028;
    localparam logic [31:0]        H2M_TABLE  = 32'h3300_00cc;

    // Control from the sequencer to the level unit
    typedef struct packed {
        logic                 dir;
        logic [DIGIT_W-1:0]   din;
        logic [REMAP_W-1:0]   remap;
    } t_level_in;

    typedef struct packed {
        logic [DIGIT_W-1:0]   dout;
        logic [REMAP_W-1:0]   remap;
    } t_level_out;

endpackage

// File: sv/hmc2d_level.sv
// One level of the conversion: remap lookup and XOR table update.
module hmc2d_level (
    input  hmc2d_pkg::t_level_in  i_lvl,
    output hmc2d_pkg::t_level_out o_lvl
);

    logic [hmc2d_pkg::DIGIT_W-1:0] w_dout;
    logic [hmc2d_pkg::DIGIT_W-1:0] w_hdig;
    logic [31:0]                   w_table;
    logic [hmc2d_pkg::REMAP_W-1:0] w_xor;

    // Output digit picked from the remap by the input digit
    assign w_dout = i_lvl.remap[{i_lvl.din, 1'b0} +: hmc2d_pkg::DIGIT_W];

    // Hilbert digit of this level selects the update byte
    always_comb begin
        if (i_lvl.dir == hmc2d_pkg::DIR_M2H) begin
            w_hdig  = w_dout;
            w_table = hmc2d_pkg::M2H_TABLE;
        end else begin
            w_hdig  = i_lvl.din;
            w_table = hmc2d_pkg::H2M_TABLE;
        end
    end

    assign w_xor = w_table[{w_hdig, 3'b000} +: hmc2d_pkg::REMAP_W];

    assign o_lvl.dout  = w_dout;
    assign o_lvl.remap = i_lvl.remap ^ w_xor;

endmodule

// File: sv/hilbert_morton_2d_convert.sv
// Top level of the 2D Morton/Hilbert converter: sequencer, config and output register.
//
// Converts a 2D Morton code to a Hilbert index (direction 0) or back
// (direction 1), one 2-bit level per clock, most significant level first.
// Input channel: i_in_valid / o_in_ready with i_code_in and i_order_bits.
// Output channel: o_out_valid / i_out_ready with o_code_out.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 direction, 1 auto_order); write only while the block is idle.
// Each item runs through its level count in ST_RUN, where the level count is
// order_bits (capped at 16), or 18 in auto mode; the single shared level
// unit is stepped once per cycle, and ST_DONE then loads the output register.
// A new beat is accepted only while the sequencer is idle, so an item is
// taken only after the previous one has left the sequencer.
// The output register holds a finished result while the receiver stalls;
// the next beat may be taken and converted meanwhile, and its result waits
// in the sequencer until the output register frees up.
// Reset (synchronous, active low) clears config, sequencer and o_out_valid.
module hilbert_morton_2d_convert (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hmc2d_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic                                i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [hmc2d_pkg::CODE_W-1:0]        i_code_in,
    input  logic [hmc2d_pkg::ORDER_W-1:0]       i_order_bits,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hmc2d_pkg::CODE_W-1:0]        o_code_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                    r_state;
    logic                          r_direction;
    logic                          r_auto_order;
    logic                          r_dir;
    logic [hmc2d_pkg::CODE_W-1:0]  r_code;
    logic [hmc2d_pkg::LVL_W-1:0]   r_lvl;
    logic [hmc2d_pkg::REMAP_W-1:0] r_remap;
    logic [hmc2d_pkg::CODE_W-1:0]  r_acc;
    logic                          r_out_valid;
    logic [hmc2d_pkg::CODE_W-1:0]  r_out_code;

    logic [hmc2d_pkg::LVL_W-1:0]   w_levels;
    logic [hmc2d_pkg::LVL_W-1:0]   w_idx;
    logic [hmc2d_pkg::DIGIT_W-1:0] w_din;
    logic                          w_in_beat;
    logic                          w_out_free;
    hmc2d_pkg::t_level_in          w_lvl_in;
    hmc2d_pkg::t_level_out         w_lvl_out;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_beat   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_code_out  = r_out_code;

    // Level count for a new beat
    always_comb begin
        if (r_auto_order) begin
            w_levels = hmc2d_pkg::AUTO_LEVELS;
        end else if (i_order_bits > hmc2d_pkg::MAX_ORDER) begin
            w_levels = hmc2d_pkg::LVL_W'(hmc2d_pkg::MAX_ORDER);
        end else begin
            w_levels = hmc2d_pkg::LVL_W'(i_order_bits);
        end
    end

    // Current input digit; digits above bit 31 read as zero
    assign w_idx = r_lvl - hmc2d_pkg::LVL_W'(1);
    always_comb begin
        if (w_idx[hmc2d_pkg::LVL_W-1]) begin
            w_din = '0;
        end else begin
            w_din = r_code[{w_idx[3:0], 1'b0} +: hmc2d_pkg::DIGIT_W];
        end
    end

    assign w_lvl_in.dir   = r_dir;
    assign w_lvl_in.din   = w_din;
    assign w_lvl_in.remap = r_remap;

    hmc2d_level u_level (
        .i_lvl (w_lvl_in),
        .o_lvl (w_lvl_out)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_auto_order <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hmc2d_pkg::CFG_DIRECTION:  r_direction  <= i_cfg_data;
                hmc2d_pkg::CFG_AUTO_ORDER: r_auto_order <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lvl   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_beat) begin
                        r_lvl   <= w_levels;
                        r_state <= (w_levels == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_lvl <= w_idx;
                    if (r_lvl == hmc2d_pkg::LVL_W'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_code  <= i_code_in;
            r_dir   <= r_direction;
            r_remap <= hmc2d_pkg::REMAP_INIT;
            r_acc   <= '0;
        end else if (r_state == ST_RUN) begin
            r_remap <= w_lvl_out.remap;
            r_acc   <= {r_acc[hmc2d_pkg::CODE_W-hmc2d_pkg::DIGIT_W-1:0], w_lvl_out.dout};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_code <= r_acc;
        end
    end

endmodule

// File: sv/hmc2d_chk.sv
// Port-level checker for the 2D Morton/Hilbert converter, bound to the top level.
module hmc2d_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [hmc2d_pkg::CODE_W-1:0]   o_code_out
);

    // Result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_code_out))
        else $error("result payload changed while stalled");

    // One item in flight: ready drops after a beat is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while converter busy");

    // No result can appear the cycle after a beat is taken
    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind hilbert_morton_2d_convert hmc2d_chk u_hmc2d_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_code_out  (o_code_out)
);
